// ===== rtl/core/cht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg: shared types and microcode for the chained hash table
// Beat payloads, status codes, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int KEY_W       = 31;
   localparam int VALUE_W     = 32;
   localparam int MOD_DIGIT_W = 4;
   localparam int MOD_STEPS   = 8;
   localparam int MOD_SRC_W   = MOD_DIGIT_W * MOD_STEPS;
   localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

   typedef enum logic {
      K_INSERT = 1'b0,
      K_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_FOUND    = 2'd2,
      ST_MISSING  = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                    kind;
      logic        [KEY_W-1:0]     key;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [VALUE_W-1:0]   found_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR    = 4'd0,
      S_IDLE     = 4'd1,
      S_MOD      = 4'd2,
      S_HEAD_RD  = 4'd3,
      S_HEAD_USE = 4'd4,
      S_INSERT   = 4'd5,
      S_WALK     = 4'd6,
      S_WALK_CMP = 4'd7,
      S_FINISH   = 4'd8
   } step_type;

   typedef enum logic [3:0] {
      A_NOP      = 4'd0,
      A_CLEAR    = 4'd1,
      A_LOAD     = 4'd2,
      A_MOD      = 4'd3,
      A_HEAD_USE = 4'd4,
      A_INSERT   = 4'd5,
      A_WALK     = 4'd6,
      A_CMP      = 4'd7,
      A_FINISH   = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      C_ALWAYS    = 3'd0,
      C_CLR_DONE  = 3'd1,
      C_REQ       = 3'd2,
      C_MOD_DONE  = 3'd3,
      C_LOOKUP    = 3'd4,
      C_NOLINK    = 3'd5,
      C_MATCH     = 3'd6,
      C_SLOT_FREE = 3'd7
   } cond_type;

   typedef struct packed {
      action_type act;
      cond_type   cond;
      step_type   target_t;
      step_type   target_f;
   } ucode_type;

   // sequencer program: condition true -> target_t, else target_f
   function automatic ucode_type ucode_fetch(step_type step);
      ucode_type word;
      unique case (step)
         S_CLEAR:    word = '{act: A_CLEAR,    cond: C_CLR_DONE,
                              target_t: S_IDLE,     target_f: S_CLEAR};
         S_IDLE:     word = '{act: A_LOAD,     cond: C_REQ,
                              target_t: S_MOD,      target_f: S_IDLE};
         S_MOD:      word = '{act: A_MOD,      cond: C_MOD_DONE,
                              target_t: S_HEAD_RD,  target_f: S_MOD};
         S_HEAD_RD:  word = '{act: A_NOP,      cond: C_ALWAYS,
                              target_t: S_HEAD_USE, target_f: S_HEAD_USE};
         S_HEAD_USE: word = '{act: A_HEAD_USE, cond: C_LOOKUP,
                              target_t: S_WALK,     target_f: S_INSERT};
         S_INSERT:   word = '{act: A_INSERT,   cond: C_ALWAYS,
                              target_t: S_FINISH,   target_f: S_FINISH};
         S_WALK:     word = '{act: A_WALK,     cond: C_NOLINK,
                              target_t: S_FINISH,   target_f: S_WALK_CMP};
         S_WALK_CMP: word = '{act: A_CMP,      cond: C_MATCH,
                              target_t: S_FINISH,   target_f: S_WALK};
         S_FINISH:   word = '{act: A_FINISH,   cond: C_SLOT_FREE,
                              target_t: S_IDLE,     target_f: S_FINISH};
         default:    word = '{act: A_NOP,      cond: C_ALWAYS,
                              target_t: S_IDLE,     target_f: S_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== rtl/core/cht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/chained_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_unit: key/value hash table with separate chaining
// Insert links a new entry at the head of bucket key % BUCKET_COUNT; lookup
// walks that chain and returns the newest match.
//
// Channels: req (kind, key, value) in, rsp (status, found_value) out, each a
// valid/stall beat. One rsp beat per req beat, in order.
// Reset: a clearing pass writes every bucket head to null, one per cycle,
// and req_stall stays high during it.
// Steps from the accepting edge to rsp_valid: the bucket index is formed
// four key bits per cycle, then the bucket head is read. An insert, unless
// the table is full, then writes its entry and the new head; a lookup walks
// the chain to the first match or its end. Each chain entry costs one
// entry-store read and one compare. Requests are taken only in idle.
// One item is in work at a time. The result sits in an output register, so
// the next request is accepted while rsp is stalled; the sequencer waits
// only when a finished result finds that register still full.
// ----------------------------------------------------------------------------
module chained_hash_table_unit
   import cht_pkg::*;
#(
   parameter int BUCKET_COUNT   = 5,
   parameter int ENTRY_CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_beat,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_beat
);

   localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int IDX_W  = $clog2(ENTRY_CAPACITY);
   localparam int LINK_W = $clog2(ENTRY_CAPACITY + 1);
   localparam int ENT_W  = KEY_W + VALUE_W + LINK_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRY_CAPACITY);
   localparam logic [BKT_W:0]    BKT_MOD   = (BKT_W + 1)'(BUCKET_COUNT);
   localparam logic [BKT_W-1:0]  CLR_LAST  = BKT_W'(BUCKET_COUNT - 1);

   step_type                  upc_ff, upc_in;
   ucode_type                 uc;
   logic                      cond_true;

   kind_type                  kind_ff;
   logic        [KEY_W-1:0]   key_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [MOD_SRC_W-1:0]      key_sh_ff;
   logic [MOD_CNT_W-1:0]      mod_cnt_ff;
   logic [BKT_W-1:0]          rem_ff, rem_in;
   logic [BKT_W-1:0]          mod_acc;
   logic [BKT_W:0]            mod_part;
   logic [LINK_W-1:0]         cur_ff;
   logic [LINK_W-1:0]         used_ff;
   logic [BKT_W-1:0]          clr_cnt_ff;
   status_type                res_status_ff;
   logic signed [VALUE_W-1:0] res_value_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_beat_ff;

   logic                      req_accept;
   logic                      slot_free;
   logic                      full;
   logic                      nolink;
   logic                      match;

   logic                      head_we;
   logic [BKT_W-1:0]          head_waddr;
   logic [LINK_W-1:0]         head_wdata;
   logic [LINK_W-1:0]         head_rdata;

   logic                      ent_we;
   logic [ENT_W-1:0]          ent_wdata;
   logic [ENT_W-1:0]          ent_rdata;
   logic [KEY_W-1:0]          ent_key;
   logic signed [VALUE_W-1:0] ent_value;
   logic [LINK_W-1:0]         ent_next;

   // control store fetch and branch
   assign uc         = ucode_fetch(upc_ff);
   assign req_stall  = (upc_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign full       = (used_ff == NULL_LINK);
   assign nolink     = (cur_ff >= used_ff);
   assign match      = (ent_key == key_ff);

   always_comb begin
      unique case (uc.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_CLR_DONE:  cond_true = (clr_cnt_ff == CLR_LAST);
         C_REQ:       cond_true = req_accept;
         C_MOD_DONE:  cond_true = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
         C_LOOKUP:    cond_true = (kind_ff == K_LOOKUP);
         C_NOLINK:    cond_true = nolink;
         C_MATCH:     cond_true = match;
         C_SLOT_FREE: cond_true = slot_free;
      endcase
      upc_in = cond_true ? uc.target_t : uc.target_f;
   end

   // restoring remainder, one key digit per step
   always_comb begin
      mod_acc  = rem_ff;
      mod_part = '0;
      for (int i = 0; i < MOD_DIGIT_W; i++) begin
         mod_part = {mod_acc, key_sh_ff[MOD_SRC_W - 1 - i]};
         if (mod_part >= BKT_MOD) begin
            mod_part = mod_part - BKT_MOD;
         end
         mod_acc = mod_part[BKT_W-1:0];
      end
      rem_in = mod_acc;
   end

   // memory ports
   assign head_we    = (uc.act == A_CLEAR) || ((uc.act == A_INSERT) && !full);
   assign head_waddr = (uc.act == A_CLEAR) ? clr_cnt_ff : rem_ff;
   assign head_wdata = (uc.act == A_CLEAR) ? NULL_LINK : used_ff;

   assign ent_we    = (uc.act == A_INSERT) && !full;
   assign ent_wdata = {key_ff, value_ff, cur_ff};
   assign ent_key   = ent_rdata[ENT_W-1 -: KEY_W];
   assign ent_value = ent_rdata[LINK_W +: VALUE_W];
   assign ent_next  = ent_rdata[LINK_W-1:0];

   cht_ram #(
      .WIDTH (LINK_W),
      .DEPTH (BUCKET_COUNT)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (rem_ff),
      .rd_data (head_rdata)
   );

   cht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRY_CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (used_ff[IDX_W-1:0]),
      .wr_data (ent_wdata),
      .rd_addr (cur_ff[IDX_W-1:0]),
      .rd_data (ent_rdata)
   );

   // sequencer state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_CLEAR;
         clr_cnt_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= ((uc.act == A_FINISH) && slot_free) ||
                         (rsp_valid_ff && rsp_stall);
         unique case (uc.act)
            A_NOP: begin
            end
            A_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            A_LOAD: begin
               if (req_accept) begin
                  kind_ff    <= req_beat.kind;
                  key_ff     <= req_beat.key;
                  value_ff   <= req_beat.value;
                  key_sh_ff  <= {1'b0, req_beat.key};
                  rem_ff     <= '0;
                  mod_cnt_ff <= '0;
               end
            end
            A_MOD: begin
               rem_ff     <= rem_in;
               key_sh_ff  <= key_sh_ff << MOD_DIGIT_W;
               mod_cnt_ff <= mod_cnt_ff + 1'b1;
            end
            A_HEAD_USE: begin
               cur_ff <= head_rdata;
            end
            A_INSERT: begin
               res_value_ff <= '0;
               if (full) begin
                  res_status_ff <= ST_FULL;
               end else begin
                  res_status_ff <= ST_INSERTED;
                  used_ff       <= used_ff + 1'b1;
               end
            end
            A_WALK: begin
               res_status_ff <= ST_MISSING;
               res_value_ff  <= '0;
            end
            A_CMP: begin
               if (match) begin
                  res_status_ff <= ST_FOUND;
                  res_value_ff  <= ent_value;
               end else begin
                  cur_ff <= ent_next;
               end
            end
            A_FINISH: begin
               if (slot_free) begin
                  rsp_beat_ff  <= '{status: res_status_ff, found_value: res_value_ff};
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= NULL_LINK)
      else $error("entry count beyond capacity");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == S_WALK_CMP) |-> (cur_ff < used_ff))
      else $error("chain walk compares an unwritten entry");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ((uc.act == A_INSERT) && !full) |=> (used_ff == $past(used_ff) + 1'b1))
      else $error("insert did not claim exactly one entry");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(upc_ff) == S_FINISH))
      else $error("result raised outside the finish step");

endmodule
